// File: sv/grid_stencil_adjacency_gen_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the grid stencil adjacency generator
// Shared concurrent assertion forms, clocked on aclk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef GRID_STENCIL_ADJACENCY_GEN_DEFINES_SVH
`define GRID_STENCIL_ADJACENCY_GEN_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define GSA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define GSA_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// A consequent that must hold in the cycle after its antecedent.
`define GSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/gsa_pkg.sv
// ---------------------------------------------------------------------------
// Grid stencil adjacency generator package
// Widths, register indexes, controller states and control structs.
// ---------------------------------------------------------------------------
package gsa_pkg;

    localparam int CFG_W        = 9;
    localparam int CFG_IDX_W    = 2;
    localparam int VAL_W        = 29;
    localparam int DIM_BITS_DEF = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_DEPTH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_STENCIL = 2'd3;

    // Result kinds.
    localparam logic KIND_NEIGHBOUR = 1'b0;
    localparam logic KIND_ROW_END   = 1'b1;

    // Offset digit codes: one step back, no step, one step forward.
    typedef logic [1:0] digit_t;
    localparam digit_t DIGIT_LO  = 2'd0;
    localparam digit_t DIGIT_MID = 2'd1;
    localparam digit_t DIGIT_HI  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_NODE,
        ST_SCAN,
        ST_TAIL
    } gsa_state_t;

    typedef struct packed {
        logic start;
        logic mul1;
        logic mul2;
        logic node;
        logic scan;
        logic tail;
    } gsa_cmd_t;

    typedef struct packed {
        logic out_free;
        logic scan_last;
    } gsa_stat_t;

endpackage

// File: sv/grid_stencil_adjacency_gen.sv
// ---------------------------------------------------------------------------
// Grid stencil adjacency generator
// Streams the compressed adjacency list of a 3-D grid, one node per item.
// ---------------------------------------------------------------------------
// Usage: program grid_width, grid_height, grid_depth and full_stencil through
// the cfg_we / cfg_index / cfg_wdata write port while the block is idle. Each
// item accepted on the s_ channel advances the row-major walk by one node;
// s_restart set returns the walk to node zero with a zero total first.
// For that node the m_ channel delivers the linear indices of its in-bounds
// neighbors (26 candidates with the full stencil, 6 face neighbors
// otherwise), then one row-end item carrying the running neighbor total
// with m_last_of_run set. m_grid_done marks every item of the last node.
// A neighbor item is registered at the earliest in the SCAN state, after the
// MUL1, MUL2 and NODE states that form the index products; the row-end
// item is registered in the TAIL state once the scan is through.
// The scan visits all 27 stencil positions at one per cycle while the result
// register is free; the row-end item follows, and the block takes no new
// item until then: s_ready returns once the row-end item is loaded.
// The scan stalls in place whenever the result register is full and
// m_ready is low; nothing is dropped.
// Reset (aresetn low, synchronous) sets all sizes and full_stencil to one,
// clears the walk position and total, and empties the result register.
// ---------------------------------------------------------------------------
module grid_stencil_adjacency_gen #(
    parameter int DIM_BITS = gsa_pkg::DIM_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [gsa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gsa_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_restart,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_item_kind,
    output logic [gsa_pkg::VAL_W-1:0]     m_item_value,
    output logic                          m_last_of_run,
    output logic                          m_grid_done
);
    import gsa_pkg::*;

    // Commands from the controller and status back from the datapath.
    gsa_cmd_t  cmd;
    gsa_stat_t stat;

    // The controller owns the input handshake and steps the datapath
    // through the index products, the stencil scan and the row-end item.
    gsa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    // The datapath holds the configuration, the walk position, the node
    // index arithmetic and the result register that faces the receiver.
    gsa_dp #(
        .DIM_BITS (DIM_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_restart     (s_restart),
        .cmd           (cmd),
        .stat          (stat),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_item_kind   (m_item_kind),
        .m_item_value  (m_item_value),
        .m_last_of_run (m_last_of_run),
        .m_grid_done   (m_grid_done)
    );

endmodule

// File: sv/gsa_ctrl.sv
// ---------------------------------------------------------------------------
// Grid stencil adjacency controller
// Sequences the index products, the neighbour scan and the row-end result.
// ---------------------------------------------------------------------------
`include "grid_stencil_adjacency_gen_defines.svh"

module gsa_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output gsa_pkg::gsa_cmd_t  cmd,
    input  gsa_pkg::gsa_stat_t stat
);
    import gsa_pkg::*;

    gsa_state_t state_reg;
    gsa_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_NODE;
            ST_NODE: state_next = ST_SCAN;
            ST_SCAN: begin
                if (stat.out_free && stat.scan_last) begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        cmd.start = (state_reg == ST_IDLE) && s_valid;
        cmd.mul1  = (state_reg == ST_MUL1);
        cmd.mul2  = (state_reg == ST_MUL2);
        cmd.node  = (state_reg == ST_NODE);
        cmd.scan  = (state_reg == ST_SCAN) && stat.out_free;
        cmd.tail  = (state_reg == ST_TAIL) && stat.out_free;
    end

    `GSA_ASSERT_NEXT(a_accept_starts, s_valid && s_ready, state_reg == ST_MUL1,
        "accepted item did not start the index products")
    `GSA_ASSERT_NEXT(a_tail_ends, (state_reg == ST_TAIL) && stat.out_free,
        state_reg == ST_IDLE, "row-end result did not end the step")

endmodule

// File: sv/gsa_dp.sv
// ---------------------------------------------------------------------------
// Grid stencil adjacency datapath
// Configuration, walk position, node index arithmetic and the result register.
// ---------------------------------------------------------------------------
`include "grid_stencil_adjacency_gen_defines.svh"

module gsa_dp #(
    parameter int DIM_BITS = gsa_pkg::DIM_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [gsa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gsa_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_restart,
    input  gsa_pkg::gsa_cmd_t             cmd,
    output gsa_pkg::gsa_stat_t            stat,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_item_kind,
    output logic [gsa_pkg::VAL_W-1:0]     m_item_value,
    output logic                          m_last_of_run,
    output logic                          m_grid_done
);
    import gsa_pkg::*;

    localparam int PW      = DIM_BITS;
    localparam int EW      = DIM_BITS + 1;
    localparam int CW      = (CFG_W > EW) ? CFG_W : EW;
    localparam int MAX_DIM = 1 << DIM_BITS;

    // A size of zero counts as one, and sizes saturate at the largest grid.
    function automatic logic [EW-1:0] eff_dim(input logic [CFG_W-1:0] v);
        logic [CW-1:0] vx;
        vx = CW'(v);
        if (vx == CW'(0)) begin
            return EW'(1);
        end else if (vx > CW'(MAX_DIM)) begin
            return EW'(MAX_DIM);
        end else begin
            return EW'(vx);
        end
    endfunction

    logic [CFG_W-1:0] width_reg, height_reg, depth_reg;
    logic             full_reg;

    logic [PW-1:0]    col_reg, row_reg, plane_reg;
    logic [PW-1:0]    col_next, row_next, plane_next;
    logic [VAL_W-1:0] total_reg, total_next;

    logic [2*EW-1:0]  pp_reg;
    logic [PW+EW-1:0] rw_reg;
    logic [VAL_W-1:0] pz_reg;
    logic [VAL_W-1:0] node_reg;
    logic             done_reg;
    digit_t           dz_reg, dy_reg, dx_reg;

    logic             out_valid_reg, out_kind_reg, out_last_reg, out_done_reg;
    logic [VAL_W-1:0] out_value_reg;

    logic [EW-1:0]    w, h, d;
    logic [EW-1:0]    wm1, hm1, dm1;
    logic             out_free, out_load;
    logic             outside, cand_valid;
    logic [1:0]       nz;
    logic [VAL_W-1:0] ppv, wv, zterm, yterm, xterm, cand_val;
    logic [PW+2*EW-1:0] pz_prod;

    assign w   = eff_dim(width_reg);
    assign h   = eff_dim(height_reg);
    assign d   = eff_dim(depth_reg);
    assign wm1 = w - EW'(1);
    assign hm1 = h - EW'(1);
    assign dm1 = d - EW'(1);

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CFG_W'(1);
            height_reg <= CFG_W'(1);
            depth_reg  <= CFG_W'(1);
            full_reg   <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_GRID_WIDTH:   width_reg  <= cfg_wdata;
                REG_GRID_HEIGHT:  height_reg <= cfg_wdata;
                REG_GRID_DEPTH:   depth_reg  <= cfg_wdata;
                REG_FULL_STENCIL: full_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // A stored position outside the current grid restarts the walk.
    assign outside = (EW'(col_reg) >= w) || (EW'(row_reg) >= h) || (EW'(plane_reg) >= d);

    // Candidate neighbour for the current offset digits.
    assign nz = {1'b0, dz_reg != DIGIT_MID} + {1'b0, dy_reg != DIGIT_MID}
              + {1'b0, dx_reg != DIGIT_MID};
    assign cand_valid = (nz != 2'd0) && (full_reg || (nz == 2'd1))
        && !((dz_reg == DIGIT_LO) && (plane_reg == PW'(0)))
        && !((dz_reg == DIGIT_HI) && (EW'(plane_reg) == dm1))
        && !((dy_reg == DIGIT_LO) && (row_reg == PW'(0)))
        && !((dy_reg == DIGIT_HI) && (EW'(row_reg) == hm1))
        && !((dx_reg == DIGIT_LO) && (col_reg == PW'(0)))
        && !((dx_reg == DIGIT_HI) && (EW'(col_reg) == wm1));

    assign ppv   = VAL_W'(pp_reg);
    assign wv    = VAL_W'(w);
    assign zterm = (dz_reg == DIGIT_LO) ? (~ppv + VAL_W'(1)) :
                   (dz_reg == DIGIT_HI) ? ppv : VAL_W'(0);
    assign yterm = (dy_reg == DIGIT_LO) ? (~wv + VAL_W'(1)) :
                   (dy_reg == DIGIT_HI) ? wv : VAL_W'(0);
    assign xterm = (dx_reg == DIGIT_LO) ? {VAL_W{1'b1}} :
                   (dx_reg == DIGIT_HI) ? VAL_W'(1) : VAL_W'(0);
    assign cand_val = node_reg + zterm + yterm + xterm;

    assign pz_prod = plane_reg * pp_reg;

    assign out_free       = !out_valid_reg || m_ready;
    assign out_load       = (cmd.scan && cand_valid) || cmd.tail;
    assign stat.out_free  = out_free;
    assign stat.scan_last = (dz_reg == DIGIT_HI) && (dy_reg == DIGIT_HI)
                         && (dx_reg == DIGIT_HI);

    // Walk position and running total.
    always_comb begin
        col_next   = col_reg;
        row_next   = row_reg;
        plane_next = plane_reg;
        total_next = total_reg;
        if (cmd.start) begin
            if (s_restart || outside) begin
                col_next   = PW'(0);
                row_next   = PW'(0);
                plane_next = PW'(0);
                total_next = VAL_W'(0);
            end
        end else if (cmd.scan && cand_valid) begin
            total_next = total_reg + VAL_W'(1);
        end else if (cmd.tail) begin
            if (done_reg) begin
                col_next   = PW'(0);
                row_next   = PW'(0);
                plane_next = PW'(0);
                total_next = VAL_W'(0);
            end else if ((EW'(col_reg) + EW'(1)) < w) begin
                col_next = col_reg + PW'(1);
            end else begin
                col_next = PW'(0);
                if ((EW'(row_reg) + EW'(1)) < h) begin
                    row_next = row_reg + PW'(1);
                end else begin
                    row_next   = PW'(0);
                    plane_next = plane_reg + PW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            plane_reg <= '0;
            total_reg <= '0;
            dz_reg    <= DIGIT_LO;
            dy_reg    <= DIGIT_LO;
            dx_reg    <= DIGIT_LO;
        end else begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            plane_reg <= plane_next;
            total_reg <= total_next;
            if (cmd.node) begin
                dz_reg <= DIGIT_LO;
                dy_reg <= DIGIT_LO;
                dx_reg <= DIGIT_LO;
            end else if (cmd.scan) begin
                if (dx_reg != DIGIT_HI) begin
                    dx_reg <= dx_reg + 2'd1;
                end else begin
                    dx_reg <= DIGIT_LO;
                    if (dy_reg != DIGIT_HI) begin
                        dy_reg <= dy_reg + 2'd1;
                    end else begin
                        dy_reg <= DIGIT_LO;
                        if (dz_reg != DIGIT_HI) begin
                            dz_reg <= dz_reg + 2'd1;
                        end
                    end
                end
            end
        end
    end

    // Node index products, formed in the MUL1, MUL2 and NODE register stages.
    always_ff @(posedge aclk) begin
        if (cmd.mul1) begin
            pp_reg   <= w * h;
            rw_reg   <= row_reg * w;
            done_reg <= (EW'(col_reg) == wm1) && (EW'(row_reg) == hm1)
                     && (EW'(plane_reg) == dm1);
        end
        if (cmd.mul2) begin
            pz_reg <= VAL_W'(pz_prod);
        end
        if (cmd.node) begin
            node_reg <= pz_reg + VAL_W'(rw_reg) + VAL_W'(col_reg);
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_kind_reg  <= cmd.tail ? KIND_ROW_END : KIND_NEIGHBOUR;
            out_value_reg <= cmd.tail ? total_reg : cand_val;
            out_last_reg  <= cmd.tail;
            out_done_reg  <= done_reg;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_item_kind   = out_kind_reg;
    assign m_item_value  = out_value_reg;
    assign m_last_of_run = out_last_reg;
    assign m_grid_done   = out_done_reg;

    `GSA_ASSERT(a_digit_range,
        (dz_reg <= DIGIT_HI) && (dy_reg <= DIGIT_HI) && (dx_reg <= DIGIT_HI),
        "offset digit out of range")
    `GSA_ASSERT_IMPL(a_load_when_free, out_load, out_free,
        "result register overwritten while still held")

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for the grid stencil adjacency generator
// Steps the block through several grid shapes and stencil modes with random
// stall patterns on both channels. Each accepted item is also run through a
// behavioral copy of the row-major walk. Every result item is then checked,
// field by field and in order, against that copy or a row's typed values.
// ---------------------------------------------------------------------------
module tb;

    import gsa_pkg::*;

    // Cycles to let pass once nothing is expected.
    localparam int DRAIN_CYCLES = 8;
    // Random items per stall phase.
    localparam int PHASE_ITEMS = 118;

    typedef enum logic {ROW_STEP, ROW_CFG} row_op_t;

    // One result item as it appears on the m_ channel.
    typedef struct {
        logic             kind;
        logic [VAL_W-1:0] value;
        logic             last;
        logic             done;
    } adj_item_t;

    // One row of the stimulus table. A step row either takes its results from
    // the walk model or, where they are obvious, carries them typed in:
    // at most one neighbor index, then the row-end total.
    typedef struct {
        row_op_t              op;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [CFG_W-1:0]     reg_value;
        logic                 restart;
        bit                   typed;
        int                   nb_cnt;
        logic [VAL_W-1:0]     nb_val;
        logic [VAL_W-1:0]     end_val;
        logic                 done;
    } plan_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_restart = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_item_kind;
    logic [VAL_W-1:0]     m_item_value;
    logic                 m_last_of_run;
    logic                 m_grid_done;

    // Register copies as last written through the write port.
    logic [CFG_W-1:0] size_w = 9'd1;
    logic [CFG_W-1:0] size_h = 9'd1;
    logic [CFG_W-1:0] size_d = 9'd1;
    logic             use_full = 1'b1;

    // Walk state: position of the next node and the running neighbor total.
    logic [7:0]       walk_col = '0;
    logic [7:0]       walk_row = '0;
    logic [7:0]       walk_plane = '0;
    logic [VAL_W-1:0] walk_total = '0;

    adj_item_t adj_expect[$];
    plan_row_t plan[$];
    int        mismatch_count = 0;
    int        send_idle_pct = 14;
    int        recv_idle_pct = 78;
    bit        cfg_open = 1'b0;

    grid_stencil_adjacency_gen dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_restart     (s_restart),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_item_kind   (m_item_kind),
        .m_item_value  (m_item_value),
        .m_last_of_run (m_last_of_run),
        .m_grid_done   (m_grid_done)
    );

    // 12 ns clock.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // The receiver decides at every falling edge whether to take a result.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    // A size of zero counts as one and anything past 256 saturates at 256.
    function automatic int unsigned eff_size(input logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > 256)
            return 256;
        return 32'(v);
    endfunction

    // Advances the walk by one node and returns the result items it causes:
    // the in-bounds neighbor indices in stencil order, then the row-end total.
    function automatic void walk_node(input logic restart_req, output adj_item_t res[$]);
        int unsigned     w, h, d;
        longint unsigned per_plane, node, nb;
        logic            at_end;
        int              moves, count;
        bit              take;
        adj_item_t       it;
        res.delete();
        w = eff_size(size_w);
        h = eff_size(size_h);
        d = eff_size(size_d);
        // A restart request, or a position that no longer fits the grid,
        // sends the walk back to node zero with a cleared total.
        if (restart_req || walk_col >= w || walk_row >= h || walk_plane >= d) begin
            walk_col = '0;
            walk_row = '0;
            walk_plane = '0;
            walk_total = '0;
        end
        per_plane = longint'(w) * h;
        node = longint'(walk_plane) * per_plane + longint'(walk_row) * w + walk_col;
        at_end = (walk_col == w - 1) && (walk_row == h - 1) && (walk_plane == d - 1);
        count = 0;
        for (int dz = -1; dz <= 1; dz++) begin
            for (int dy = -1; dy <= 1; dy++) begin
                for (int dx = -1; dx <= 1; dx++) begin
                    moves = (dz != 0) + (dy != 0) + (dx != 0);
                    take = (moves != 0) && (use_full || moves == 1);
                    if (dz < 0 && walk_plane == 0) take = 1'b0;
                    if (dz > 0 && walk_plane == d - 1) take = 1'b0;
                    if (dy < 0 && walk_row == 0) take = 1'b0;
                    if (dy > 0 && walk_row == h - 1) take = 1'b0;
                    if (dx < 0 && walk_col == 0) take = 1'b0;
                    if (dx > 0 && walk_col == w - 1) take = 1'b0;
                    if (take) begin
                        nb = node;
                        if (dz < 0) nb -= per_plane;
                        if (dz > 0) nb += per_plane;
                        if (dy < 0) nb -= w;
                        if (dy > 0) nb += w;
                        if (dx < 0) nb -= 1;
                        if (dx > 0) nb += 1;
                        it.kind = KIND_NEIGHBOUR;
                        it.value = nb[VAL_W-1:0];
                        it.last = 1'b0;
                        it.done = at_end;
                        res.push_back(it);
                        count++;
                    end
                end
            end
        end
        walk_total = walk_total + VAL_W'(count);
        it.kind = KIND_ROW_END;
        it.value = walk_total;
        it.last = 1'b1;
        it.done = at_end;
        res.push_back(it);
        // Step to the next node, wrapping to zero after the last one.
        if (at_end) begin
            walk_col = '0;
            walk_row = '0;
            walk_plane = '0;
            walk_total = '0;
        end else if (walk_col + 1 < w) begin
            walk_col++;
        end else begin
            walk_col = '0;
            if (walk_row + 1 < h) begin
                walk_row++;
            end else begin
                walk_row = '0;
                walk_plane++;
            end
        end
    endfunction

    function automatic void check_field(input string name, input logic [VAL_W-1:0] want,
                                        input logic [VAL_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Every result taken by the receiver is matched against the oldest
    // expectation still waiting.
    always @(posedge aclk) begin : check_result
        adj_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (adj_expect.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %0d value %0d",
                         $time, m_item_kind, m_item_value);
                mismatch_count++;
            end else begin
                want = adj_expect.pop_front();
                check_field("item_kind", VAL_W'(want.kind), VAL_W'(m_item_kind));
                check_field("item_value", want.value, m_item_value);
                check_field("last_of_run", VAL_W'(want.last), VAL_W'(m_last_of_run));
                check_field("grid_done", VAL_W'(want.done), VAL_W'(m_grid_done));
            end
        end
    end

    // Table builders for the directed part.
    function automatic void plan_cfg(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_W-1:0] value);
        plan_row_t r;
        r = '{op: ROW_CFG, default: '0};
        r.reg_index = idx;
        r.reg_value = value;
        plan.push_back(r);
    endfunction

    function automatic void plan_step(input logic restart);
        plan_row_t r;
        r = '{op: ROW_STEP, default: '0};
        r.restart = restart;
        plan.push_back(r);
    endfunction

    function automatic void plan_typed(input logic restart, input int nb_cnt,
                                       input logic [VAL_W-1:0] nb_val,
                                       input logic [VAL_W-1:0] end_val, input logic done);
        plan_row_t r;
        r.op = ROW_STEP;
        r.reg_index = '0;
        r.reg_value = '0;
        r.restart = restart;
        r.typed = 1'b1;
        r.nb_cnt = nb_cnt;
        r.nb_val = nb_val;
        r.end_val = end_val;
        r.done = done;
        plan.push_back(r);
    endfunction

    // Drops valid, waits for every expected result, then lets the block settle.
    // Called at a falling edge; returns at a falling edge.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (adj_expect.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Drives one register write for one cycle. The write enable is lowered by
    // the caller once the batch is over, so back-to-back writes never lower
    // and raise it within one time step.
    task automatic set_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        cfg_open = 1'b1;
        case (idx)
            REG_GRID_WIDTH:   size_w = value;
            REG_GRID_HEIGHT:  size_h = value;
            REG_GRID_DEPTH:   size_d = value;
            REG_FULL_STENCIL: use_full = value[0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic close_cfg();
        if (cfg_open) begin
            cfg_we <= 1'b0;
            cfg_open = 1'b0;
        end
    endtask

    // Offers one item after a random idle gap and waits for it to be taken.
    // The walk model runs at the accepting edge. Returns at a falling edge
    // with valid still high, so the next item can follow without a gap.
    task automatic send_step(input plan_row_t row);
        adj_item_t predicted[$];
        adj_item_t it;
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            s_restart <= 1'($urandom_range(1, 0));
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_restart <= row.restart;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        walk_node(row.restart, predicted);
        if (row.typed) begin
            if (row.nb_cnt == 1) begin
                it.kind = KIND_NEIGHBOUR;
                it.value = row.nb_val;
                it.last = 1'b0;
                it.done = row.done;
                adj_expect.push_back(it);
            end
            it.kind = KIND_ROW_END;
            it.value = row.end_val;
            it.last = 1'b1;
            it.done = row.done;
            adj_expect.push_back(it);
        end else begin
            foreach (predicted[i])
                adj_expect.push_back(predicted[i]);
        end
        @(negedge aclk);
    endtask

    // Picks new register values while the block is idle: mostly small grids
    // so that walks run to their last node and wrap, now and then huge or
    // zero sizes that saturate or clamp.
    task automatic random_config(output bit big_grid);
        logic [CFG_IDX_W-1:0] ri;
        big_grid = ($urandom_range(7, 0) == 0);
        for (int i = 0; i < 4; i++) begin
            ri = CFG_IDX_W'(i);
            if ($urandom_range(9, 0) < 7) begin
                if (ri == REG_FULL_STENCIL)
                    set_register(ri, CFG_W'($urandom_range(1, 0)));
                else if (big_grid)
                    set_register(ri, CFG_W'($urandom_range(511, 0)));
                else
                    set_register(ri, CFG_W'($urandom_range(4, 0)));
            end
        end
        close_cfg();
    endtask

    // Random steps under the current stall setting, in bursts of one grid
    // setting each. Most bursts walk a whole small grid so the wrap is seen;
    // restarts are sprinkled in.
    task automatic random_phase(input int items);
        plan_row_t row;
        bit        big_grid;
        int        burst;
        int        nodes;
        row = '{op: ROW_STEP, default: '0};
        while (items > 0) begin
            wait_drained();
            random_config(big_grid);
            nodes = eff_size(size_w) * eff_size(size_h) * eff_size(size_d);
            if (big_grid)
                burst = $urandom_range(12, 3);
            else
                burst = nodes + $urandom_range(4, 0);
            if (burst > items)
                burst = items;
            repeat (burst) begin
                row.restart = ($urandom_range(19, 0) == 0);
                send_step(row);
            end
            items -= burst;
        end
    endtask

    // Main sequence: reset, the directed table, then three random phases.
    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset grid is a single node: only the row-end item, total zero,
        // flagged as the last node, with and without restart.
        plan_typed(1'b0, 0, 0, 0, 1'b1);
        plan_typed(1'b1, 0, 0, 0, 1'b1);
        // A two-node row with face neighbors only: each node sees the other,
        // then the walk wraps back to node zero with a fresh total.
        plan_cfg(REG_GRID_WIDTH, 9'd2);
        plan_cfg(REG_FULL_STENCIL, 9'd0);
        plan_typed(1'b0, 1, 1, 1, 1'b0);
        plan_typed(1'b0, 1, 0, 2, 1'b1);
        plan_typed(1'b0, 1, 1, 1, 1'b0);
        // Zero sizes count as one; the stored column no longer fits, so the
        // walk starts over at node zero.
        plan_cfg(REG_GRID_WIDTH, 9'd0);
        plan_cfg(REG_GRID_HEIGHT, 9'd0);
        plan_cfg(REG_GRID_DEPTH, 9'd0);
        plan_typed(1'b0, 0, 0, 0, 1'b1);
        // A 3x3x3 cube with the full stencil up to its center node, which has
        // all 26 neighbors.
        plan_cfg(REG_GRID_WIDTH, 9'd3);
        plan_cfg(REG_GRID_HEIGHT, 9'd3);
        plan_cfg(REG_GRID_DEPTH, 9'd3);
        plan_cfg(REG_FULL_STENCIL, 9'd1);
        repeat (14) plan_step(1'b0);
        // Oversized values saturate at 256; restart in the middle of a walk.
        plan_cfg(REG_GRID_WIDTH, 9'd511);
        plan_cfg(REG_GRID_HEIGHT, 9'd256);
        plan_cfg(REG_GRID_DEPTH, 9'd511);
        plan_step(1'b1);
        plan_step(1'b0);
        plan_step(1'b0);
        // Narrowing that still holds the position continues the walk.
        plan_cfg(REG_GRID_WIDTH, 9'd5);
        plan_step(1'b0);
        // Narrowing past the position sends the walk back to node zero.
        plan_cfg(REG_GRID_WIDTH, 9'd2);
        plan_step(1'b0);

        foreach (plan[i]) begin
            if (plan[i].op == ROW_CFG) begin
                if (!cfg_open)
                    wait_drained();
                set_register(plan[i].reg_index, plan[i].reg_value);
            end else begin
                close_cfg();
                send_step(plan[i]);
            end
        end
        close_cfg();

        // Sender rarely idles, receiver mostly stalls.
        random_phase(PHASE_ITEMS);
        wait_drained();
        send_idle_pct = 78;
        recv_idle_pct = 14;
        random_phase(PHASE_ITEMS);
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(PHASE_ITEMS);

        // Let everything drain, then watch a while longer for stray results.
        wait_drained();
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Guard against a hung handshake: 10 ms is far beyond the slowest
    // legal run of this stimulus.
    initial begin
        #10000000;
        $display("FAIL");
        $finish;
    end

endmodule
